>>> src/ascs_pkg.sv
// ----------------------------------------------------------------------------
// ascs_pkg
// Shared constants and types of the ascending sort block.
// ----------------------------------------------------------------------------
package ascs_pkg;

  localparam int MAX_ITEMS_DEF  = 64;
  localparam int VALUE_BITS_DEF = 32;
  localparam int IN_VALUE_W     = 32;
  localparam int OUT_VALUE_W    = 32;

  typedef struct packed {
    logic ins;
    logic pop;
  } ascs_ctl_t;

endpackage

>>> src/ascs_if.sv
// ----------------------------------------------------------------------------
// ascs_if
// Valid/ready channels of the ascending sort block: the element input and
// the sorted result output.
// ----------------------------------------------------------------------------
interface ascs_in_if import ascs_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [IN_VALUE_W-1:0] value;
  logic                  final_item;

  modport source (output valid, output value, output final_item, input ready);
  modport sink   (input valid, input value, input final_item, output ready);
endinterface

interface ascs_out_if import ascs_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [OUT_VALUE_W-1:0] sorted_value;
  logic                   final_result;
  logic                   overflow;

  modport source (output valid, output sorted_value, output final_result,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input final_result,
                  input overflow, output ready);
endinterface

>>> src/ascs_cell.sv
// ----------------------------------------------------------------------------
// ascs_cell
// One cell of the sorting chain. It holds one element and, on an insert,
// either keeps it, takes the new element or takes its left neighbour's
// element; on a pop it takes its right neighbour's element.
// ----------------------------------------------------------------------------
module ascs_cell import ascs_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  ascs_ctl_t             ctl,
  input  logic [VALUE_BITS-1:0] ins_val,
  input  logic [VALUE_BITS-1:0] prev_val,
  input  logic                  prev_occ,
  input  logic                  prev_gt,
  input  logic                  self_occ,
  input  logic [VALUE_BITS-1:0] next_val,
  output logic [VALUE_BITS-1:0] val,
  output logic                  gt
);

  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] val_nxt;

  assign gt  = self_occ && (val_r > ins_val);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.pop) begin
      val_nxt = next_val;
    end else if (ctl.ins) begin
      if (prev_gt) begin
        val_nxt = prev_val;
      end else if (gt || (!self_occ && prev_occ)) begin
        val_nxt = ins_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

>>> src/ascending_sort.sv
// ----------------------------------------------------------------------------
// ascending_sort
// Collects a sequence of unsigned elements and emits them in ascending order.
// ----------------------------------------------------------------------------
// Elements are taken one item per cycle and inserted at once into a chain of
// MAX_ITEMS cells that is kept in ascending order, equal elements in arrival
// order. After the item marked as last, input is held off and the n stored
// elements leave from the head of the chain, one item per cycle while the
// output is ready. Elements beyond MAX_ITEMS are dropped and every result of
// that sequence carries the overflow flag.
module ascending_sort import ascs_pkg::*; #(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ascs_in_if.sink    in_ch,
  ascs_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_DRAIN   = 1'b1;

  logic                  state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  in_acc, out_acc, full;
  ascs_ctl_t             ctl;
  logic [VALUE_BITS-1:0] ins_val;
  logic [VALUE_BITS-1:0] cell_val [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]  cell_gt;
  logic [MAX_ITEMS-1:0]  occ;

  generate
    if (VALUE_BITS <= IN_VALUE_W) begin : g_in_narrow
      assign ins_val = in_ch.value[VALUE_BITS-1:0];
    end else begin : g_in_wide
      assign ins_val = {{(VALUE_BITS-IN_VALUE_W){1'b0}}, in_ch.value};
    end
    if (VALUE_BITS >= OUT_VALUE_W) begin : g_out_narrow
      assign out_ch.sorted_value = cell_val[0][OUT_VALUE_W-1:0];
    end else begin : g_out_wide
      assign out_ch.sorted_value = {{(OUT_VALUE_W-VALUE_BITS){1'b0}}, cell_val[0]};
    end
  endgenerate

  assign in_ch.ready         = (state_r == ST_COLLECT);
  assign out_ch.valid        = (state_r == ST_DRAIN);
  assign out_ch.final_result = (count_r == CNT_W'(1));
  assign out_ch.overflow     = ovf_r;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign full    = (count_r == CNT_W'(MAX_ITEMS));
  assign ctl.ins = in_acc && !full;
  assign ctl.pop = out_acc;

  genvar i;
  generate
    for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
      assign occ[i] = (CNT_W'(i) < count_r);
      if (i == 0) begin : g_head
        ascs_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .ins_val  (ins_val),
          .prev_val (ins_val),
          .prev_occ (1'b1),
          .prev_gt  (1'b0),
          .self_occ (occ[i]),
          .next_val (cell_val[i+1]),
          .val      (cell_val[i]),
          .gt       (cell_gt[i])
        );
      end else if (i == MAX_ITEMS - 1) begin : g_tail
        ascs_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .ins_val  (ins_val),
          .prev_val (cell_val[i-1]),
          .prev_occ (occ[i-1]),
          .prev_gt  (cell_gt[i-1]),
          .self_occ (occ[i]),
          .next_val (cell_val[i]),
          .val      (cell_val[i]),
          .gt       (cell_gt[i])
        );
      end else begin : g_mid
        ascs_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .ins_val  (ins_val),
          .prev_val (cell_val[i-1]),
          .prev_occ (occ[i-1]),
          .prev_gt  (cell_gt[i-1]),
          .self_occ (occ[i]),
          .next_val (cell_val[i+1]),
          .val      (cell_val[i]),
          .gt       (cell_gt[i])
        );
      end
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_COLLECT: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_ch.final_item) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          count_nxt = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            state_nxt = ST_COLLECT;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("Input and output are both open.");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ITEMS))
    else $error("Element count exceeds capacity.");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (count_r != '0))
    else $error("Draining an empty chain.");

  a_final_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.final_item) |=> (state_r == ST_DRAIN))
    else $error("Last item did not start the result burst.");

  a_last_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.final_result) |=> (state_r == ST_COLLECT && !ovf_r
                                          && count_r == '0))
    else $error("State not cleared after the last result.");

endmodule

>>> test/sort_checker.sv
// ----------------------------------------------------------------------------
// sort_checker
// Watches both channels of the ascending sort block. It collects each
// sequence as the elements are accepted and sorts the sequence itself once its
// last item has gone in. Each accepted result is then compared field by field
// with the oldest sorted element still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sort_checker import ascs_pkg::*; #(
  parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ascs_in_if   in_mon,
  ascs_out_if  out_mon,
  output int   fail_count,
  output int   pending_results
);

  localparam int KEEP_BITS = (VALUE_BITS < IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;
  localparam logic [IN_VALUE_W-1:0] VALUE_MASK =
    {IN_VALUE_W{1'b1}} >> (IN_VALUE_W - KEEP_BITS);

  typedef struct packed {
    logic [OUT_VALUE_W-1:0] sorted_value;
    logic                   final_result;
    logic                   overflow;
  } sort_result_t;

  logic [IN_VALUE_W-1:0] collected[$];
  logic                  dropped_any;
  sort_result_t          sorted_due[$];

  // Insertion sort keeps equal elements in their arrival order.
  task automatic release_sorted_sequence();
    int                    i;
    int                    j;
    logic [IN_VALUE_W-1:0] key;
    sort_result_t          res;
    for (i = 1; i < collected.size(); i++) begin
      key = collected[i];
      j = i;
      while (j > 0 && collected[j-1] > key) begin
        collected[j] = collected[j-1];
        j--;
      end
      collected[j] = key;
    end
    for (i = 0; i < collected.size(); i++) begin
      res.sorted_value = collected[i][OUT_VALUE_W-1:0];
      res.final_result = (i == collected.size() - 1);
      res.overflow     = dropped_any;
      sorted_due.push_back(res);
    end
    collected.delete();
    dropped_any = 1'b0;
  endtask

  always @(posedge clk) begin : monitor
    sort_result_t due;
    if (!rst_n) begin
      collected.delete();
      sorted_due.delete();
      dropped_any     = 1'b0;
      fail_count      = 0;
      pending_results = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (collected.size() < MAX_ITEMS) begin
          collected.push_back(in_mon.value & VALUE_MASK);
        end else begin
          dropped_any = 1'b1;
        end
        if (in_mon.final_item) begin
          release_sorted_sequence();
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (sorted_due.size() == 0) begin
          $error("unexpected result item: sorted_value %08h", out_mon.sorted_value);
          fail_count++;
        end else begin
          due = sorted_due.pop_front();
          if (out_mon.sorted_value !== due.sorted_value) begin
            $error("sorted_value: expected %08h, got %08h",
                   due.sorted_value, out_mon.sorted_value);
            fail_count++;
          end
          if (out_mon.final_result !== due.final_result) begin
            $error("final_result: expected %0b, got %0b",
                   due.final_result, out_mon.final_result);
            fail_count++;
          end
          if (out_mon.overflow !== due.overflow) begin
            $error("overflow: expected %0b, got %0b", due.overflow, out_mon.overflow);
            fail_count++;
          end
        end
      end
      pending_results = sorted_due.size();
    end
  end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives sequences into the ascending sort block and gives the verdict. A
// short directed run covers the extreme values, equal values and single
// elements. Random sequences follow, among them ones that fill the store
// exactly and ones that overflow it, with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import ascs_pkg::*;;

  localparam int CLK_PERIOD    = 20;
  localparam int IDLE_LIMIT    = 4000;
  localparam int RANDOM_ITEMS  = 190;
  localparam int SETTLE_CYCLES = 32;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_results;
  int   idle_cycles;

  ascs_in_if  in_ch ();
  ascs_out_if out_ch ();

  ascending_sort #(
    .MAX_ITEMS  (MAX_ITEMS_DEF),
    .VALUE_BITS (VALUE_BITS_DEF)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sort_checker #(
    .MAX_ITEMS  (MAX_ITEMS_DEF),
    .VALUE_BITS (VALUE_BITS_DEF)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [IN_VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return '1;
      2, 3: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic [IN_VALUE_W-1:0] v, input logic is_final,
                           input bit steady);
    int gap;
    gap = steady ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.value      <= v;
    in_ch.final_item <= is_final;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_sequence(input int len, input bit steady);
    for (int i = 0; i < len; i++) begin
      send_item(pick_value(), i == len - 1, steady);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  initial begin : result_sink
    int stall;
    int burst;
    out_ch.ready = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 16);
      @(negedge clk);
      out_ch.ready <= 1'b1;
      repeat (burst - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int seq_idx;
    int len;
    int sent;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.value      = '0;
    in_ch.final_item = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item('0, 1'b1, 1'b0);
    send_item('1, 1'b1, 1'b0);
    send_item('1, 1'b0, 1'b0);
    send_item('0, 1'b0, 1'b0);
    send_item(32'd7, 1'b0, 1'b0);
    send_item(32'd7, 1'b0, 1'b0);
    send_item(32'h8000_0000, 1'b0, 1'b0);
    send_item(32'd1, 1'b1, 1'b0);
    for (int i = 0; i < 8; i++) begin
      send_item(32'hF000_0000 - i * 32'h1111_1111, i == 7, 1'b1);
    end
    send_item(32'd5, 1'b0, 1'b0);
    send_item(32'd5, 1'b0, 1'b0);
    send_item(32'd5, 1'b1, 1'b0);
    drain_results();

    sent    = 0;
    seq_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      if (seq_idx == 1) begin
        len = MAX_ITEMS_DEF;
      end else if (seq_idx == 4) begin
        len = MAX_ITEMS_DEF + 3;
      end else if ($urandom_range(0, 11) == 0) begin
        len = $urandom_range(MAX_ITEMS_DEF - 4, MAX_ITEMS_DEF + 6);
      end else begin
        len = $urandom_range(1, 12);
      end
      send_sequence(len, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) begin
        drain_results();
      end
      sent += len;
      seq_idx++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> ascending_sort.f
src/ascs_pkg.sv
src/ascs_if.sv
src/ascs_cell.sv
src/ascending_sort.sv
test/sort_checker.sv
test/tb_top.sv
